/* rtl/plpat_pkg.sv */
// ----------------------------------------------------------------------------
// plpat_pkg: shared types and constants
// Operation codes, status codes and field widths for the polyline block.
// ----------------------------------------------------------------------------
package plpat_pkg;

  localparam int unsigned MaxPointsDefault = 16;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned SegLenW = 17;
  localparam int unsigned TotalW  = 21;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned SegIdxW = 4;
  localparam logic [TimeW-1:0] DurationReset = 16'd1000;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic [TimeW-1:0]         query_time;
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic [SegIdxW-1:0]       segment_index;
    logic [1:0]               status;
  } rsp_t;

endpackage

/* rtl/plpat_if.sv */
// ----------------------------------------------------------------------------
// plpat_req_if / plpat_rsp_if: valid/ready channels
// Request and response channels of the polyline block.
// ----------------------------------------------------------------------------
interface plpat_req_if;
  logic             valid;
  logic             ready;
  plpat_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface plpat_rsp_if;
  logic             valid;
  logic             ready;
  plpat_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/plpat_ram.sv */
// ----------------------------------------------------------------------------
// plpat_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plpat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/plpat_divu.sv */
// ----------------------------------------------------------------------------
// plpat_divu: restoring unsigned divider
// One quotient bit per cycle; also used as integer square root.
// ----------------------------------------------------------------------------
module plpat_divu #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 21
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            sqrt_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam int unsigned RemW = NumW + 2;

  logic [NumW-1:0] num_q, num_d, quo_q, quo_d;
  logic [RemW-1:0] rem_q, rem_d, trial;
  logic [DenW-1:0] den_q;
  logic            sqrt_q, busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RemW-1:0] rem_sh;

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_sh = '0;
    trial  = '0;
    if (start_i) begin
      num_d  = num_i;
      quo_d  = '0;
      rem_d  = '0;
      busy_d = 1'b1;
      cnt_d  = sqrt_i ? CntW'(NumW / 2) : CntW'(NumW);
    end else if (busy_q) begin
      if (sqrt_q) begin
        rem_sh = {rem_q[RemW-3:0], num_q[NumW-1:NumW-2]};
        num_d  = {num_q[NumW-3:0], 2'b00};
        trial  = {quo_q[RemW-3:0], 2'b01};
      end else begin
        rem_sh = {rem_q[RemW-2:0], num_q[NumW-1]};
        num_d  = {num_q[NumW-2:0], 1'b0};
        trial  = RemW'(den_q);
      end
      if (rem_sh >= trial) begin
        rem_d = rem_sh - trial;
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q  <= den_i;
      sqrt_q <= sqrt_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

/* rtl/polyline_point_at_time.sv */
// ----------------------------------------------------------------------------
// polyline_point_at_time: position along a polyline at a given time
// Point store, segment lengths and a sequencer for clear, append and query.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink) takes one operation per transfer: clear, append or query.
//   rsp (source) gives exactly one result per request, in order.
//   path_duration is written through cfg_we_i / cfg_wdata_i while idle.
// Sequencing (one request at a time; the serial divider is shared),
// from the request transfer to result valid:
//   clear, unused op, full append, first append, empty or time-zero
//   query: read state, then output state.
//   other append: square root over 20 bit pairs, one pair a cycle.
//   query on one point or at/past the duration: read, point read, output.
//   other queries: distance division, a scan of up to MAX_POINTS-1 segment
//   lengths (one RAM read a cycle), point reads, then two interpolation
//   divisions.
// The result waits in an output register; req is not ready until the
// result has transferred, so a stalled receiver stalls the sender.
// Reset empties the path and sets path_duration to 1000; the store RAMs
// are not cleared, only entries below the point count are ever used.
// ----------------------------------------------------------------------------
module polyline_point_at_time #(
  parameter int unsigned MaxPoints = plpat_pkg::MaxPointsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [plpat_pkg::TimeW-1:0]  cfg_wdata_i,
  plpat_req_if.sink                    req,
  plpat_rsp_if.source                  rsp
);
  localparam int unsigned AW   = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned CW   = plpat_pkg::CoordW;
  localparam int unsigned LW   = plpat_pkg::SegLenW;
  localparam int unsigned TW   = plpat_pkg::TotalW;
  localparam int unsigned NW   = 40;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD0   = 11'b00000000010,
    S_APSQ  = 11'b00000000100,
    S_APWT  = 11'b00000001000,
    S_QDIV  = 11'b00000010000,
    S_SCAN  = 11'b00000100000,
    S_SCNW  = 11'b00001000000,
    S_PTRD  = 11'b00010000000,
    S_DIVX  = 11'b00100000000,
    S_DIVY  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  plpat_pkg::req_t req_q;
  plpat_pkg::rsp_t rsp_q, rsp_d;
  logic [CntW-1:0] count_q, count_d;
  logic [TW-1:0]   total_q, total_d;
  logic [plpat_pkg::TimeW-1:0] dur_q;
  logic [AW-1:0]   idx_q, idx_d;
  logic [TW:0]     run_q, run_d;
  logic [TW-1:0]   dist_q, dist_d;
  logic signed [CW-1:0] x0_q, y0_q, x1_q, y1_q;
  logic [LW-1:0]   len_q;
  logic [TW:0]     m_q;
  logic            neg_q;
  logic [1:0]      rdph_q, rdph_d;

  logic            pw_we, sl_we;
  logic [AW-1:0]   pw_addr, p_raddr, sl_raddr;
  logic [2*CW-1:0] pw_data, p_rdata;
  logic [LW-1:0]   sl_rdata, sqrt_len;

  logic            dv_start, dv_sqrt, dv_done;
  logic [NW-1:0]   dv_num, dv_quo;
  logic [TW-1:0]   dv_den;

  logic signed [CW:0]   dx, dy, dsel;
  logic signed [2*CW+1:0] dx2, dy2;
  logic [2*CW+1:0]      sq;
  logic [CW:0]          dabs;
  logic [TW+CW:0]       prod;
  logic signed [CW+1:0] qs;
  logic [TW+1:0]        tot_sum;
  logic [TW:0]          run_nx;
  logic [CntW-1:0]      last_c, seg_c;

  plpat_ram #(.Width(2 * CW), .Depth(MaxPoints)) u_pts (
    .clk_i, .we_i(pw_we), .waddr_i(pw_addr), .wdata_i(pw_data),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  plpat_ram #(.Width(LW), .Depth(MaxPoints)) u_len (
    .clk_i, .we_i(sl_we), .waddr_i(idx_q), .wdata_i(sqrt_len),
    .raddr_i(sl_raddr), .rdata_o(sl_rdata)
  );

  plpat_divu #(.NumW(NW), .DenW(TW)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .sqrt_i(dv_sqrt),
    .num_i(dv_num), .den_i(dv_den), .done_o(dv_done), .quo_o(dv_quo)
  );

  assign req.ready = state_q[0] && !rsp.valid;
  assign rsp.data  = rsp_q;

  assign dx = {x1_q[CW-1], x1_q} - {x0_q[CW-1], x0_q};
  assign dy = {y1_q[CW-1], y1_q} - {y0_q[CW-1], y0_q};
  assign dx2 = (2*CW+2)'(dx) * (2*CW+2)'(dx);
  assign dy2 = (2*CW+2)'(dy) * (2*CW+2)'(dy);
  assign sq = $unsigned(dx2) + $unsigned(dy2);
  assign sqrt_len = dv_quo[LW-1:0];
  assign tot_sum  = (TW+2)'(total_q) + (TW+2)'(sqrt_len);
  assign dsel = (state_q == S_DIVY) ? dy : dx;
  assign dabs = dsel[CW] ? (CW+1)'(-dsel) : (CW+1)'(dsel);
  assign prod = (TW+CW+1)'(dabs) * (TW+CW+1)'(m_q);
  assign qs   = neg_q ? -$signed({1'b0, dv_quo[CW:0]}) : $signed({1'b0, dv_quo[CW:0]});
  assign run_nx = run_q + (TW+1)'(sl_rdata);
  assign last_c = count_q - 1'b1;
  assign seg_c  = (count_q >= CntW'(2)) ? count_q - CntW'(2) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      total_q   <= '0;
      dur_q     <= plpat_pkg::DurationReset;
      rsp.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      if (cfg_we_i) dur_q <= cfg_wdata_i;
      if (state_q == S_OUT) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) req_q <= req.data;
    rsp_q  <= rsp_d;
    idx_q  <= idx_d;
    run_q  <= run_d;
    dist_q <= dist_d;
    rdph_q <= rdph_d;
    if (state_q == S_RD0) begin
      x0_q <= p_rdata[2*CW-1:CW];
      y0_q <= p_rdata[CW-1:0];
      x1_q <= req_q.point_x;
      y1_q <= req_q.point_y;
    end
    if (state_q == S_PTRD && rdph_q == 2'd1) begin
      x0_q <= p_rdata[2*CW-1:CW];
      y0_q <= p_rdata[CW-1:0];
    end
    if (state_q == S_PTRD && rdph_q == 2'd2) begin
      x1_q <= p_rdata[2*CW-1:CW];
      y1_q <= p_rdata[CW-1:0];
    end
    if (state_q == S_SCNW) begin
      len_q <= sl_rdata;
      m_q   <= (TW+1)'(dist_q) - run_q;
    end
    if (dv_start) neg_q <= dsel[CW];
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    total_d  = total_q;
    rsp_d    = rsp_q;
    idx_d    = idx_q;
    run_d    = run_q;
    dist_d   = dist_q;
    rdph_d   = rdph_q;
    pw_we    = 1'b0;
    pw_addr  = count_q[AW-1:0];
    pw_data  = {req_q.point_x, req_q.point_y};
    sl_we    = 1'b0;
    p_raddr  = idx_q;
    sl_raddr = idx_q;
    dv_start = 1'b0;
    dv_sqrt  = 1'b0;
    dv_num   = '0;
    dv_den   = '0;
    case (state_q)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          rsp_d = '0;
          idx_d = '0;
          run_d = '0;
          rdph_d = '0;
          state_d = S_RD0;
          // append needs the previous point, a query the first one
          p_raddr = (req.data.operation == plpat_pkg::OP_APPEND) ? AW'(last_c) : '0;
        end
      end
      S_RD0: begin
        state_d = S_OUT;
        case (plpat_pkg::op_e'(req_q.operation))
          plpat_pkg::OP_CLEAR: begin
            count_d = '0;
            total_d = '0;
          end
          plpat_pkg::OP_APPEND: begin
            if (count_q >= CntW'(MaxPoints)) begin
              rsp_d.status = plpat_pkg::ST_FULL;
            end else begin
              pw_we = 1'b1;
              count_d = count_q + 1'b1;
              if (count_q != '0) begin
                idx_d = AW'(last_c);
                state_d = S_APSQ;
              end
            end
          end
          plpat_pkg::OP_QUERY: begin
            if (count_q == '0) begin
              rsp_d.status = plpat_pkg::ST_EMPTY;
            end else if (count_q < CntW'(2) || req_q.query_time >= dur_q) begin
              idx_d = AW'(last_c);
              p_raddr = AW'(last_c);
              rsp_d.segment_index = plpat_pkg::SegIdxW'(seg_c);
              state_d = S_PTRD;
              rdph_d = 2'd3;
            end else if (req_q.query_time == '0) begin
              rsp_d.pos_x = p_rdata[2*CW-1:CW];
              rsp_d.pos_y = p_rdata[CW-1:0];
            end else begin
              dv_start = 1'b1;
              dv_num = NW'((TW+CW)'(total_q) * (TW+CW)'(req_q.query_time));
              dv_den = TW'(dur_q);
              state_d = S_QDIV;
            end
          end
          default: ;
        endcase
      end
      S_APSQ: begin
        // in the cycle after x0/x1 capture: launch the square root
        dv_start = 1'b1;
        dv_sqrt  = 1'b1;
        dv_num   = NW'(sq);
        state_d  = S_APWT;
      end
      S_APWT: begin
        if (dv_done) begin
          sl_we = 1'b1;
          total_d = tot_sum[TW+1:TW] != '0 ? {TW{1'b1}} : tot_sum[TW-1:0];
          state_d = S_OUT;
        end
      end
      S_QDIV: begin
        if (dv_done) begin
          dist_d = dv_quo[TW-1:0];
          sl_raddr = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // sl_rdata holds length of segment idx_q
        if (run_nx >= (TW+1)'(dist_q)) begin
          state_d = S_SCNW;
        end else if ((CntW'(idx_q) + CntW'(2)) >= count_q) begin
          idx_d = AW'(last_c);
          p_raddr = AW'(last_c);
          rsp_d.segment_index = plpat_pkg::SegIdxW'(seg_c);
          rdph_d = 2'd3;
          state_d = S_PTRD;
        end else begin
          run_d = run_nx;
          idx_d = idx_q + 1'b1;
          sl_raddr = idx_q + 1'b1;
        end
      end
      S_SCNW: begin
        rsp_d.segment_index = plpat_pkg::SegIdxW'(idx_q);
        rdph_d = 2'd0;
        state_d = S_PTRD;
      end
      S_PTRD: begin
        // read p[idx], then p[idx+1]; phase 3 = emit p[idx] directly
        rdph_d = rdph_q + 1'b1;
        if (rdph_q == 2'd3 || rdph_q == 2'd0) p_raddr = idx_q;
        else p_raddr = idx_q + 1'b1;
        if (rdph_q == 2'd2) begin
          if (len_q == '0) begin
            rsp_d.pos_x = x0_q;
            rsp_d.pos_y = y0_q;
            state_d = S_OUT;
          end else begin
            state_d = S_DIVX;
            rdph_d = 2'd0;
          end
        end
        if (rdph_q == 2'd3) begin
          rdph_d = 2'd3;
          state_d = S_OUT;
          rsp_d.pos_x = p_rdata[2*CW-1:CW];
          rsp_d.pos_y = p_rdata[CW-1:0];
        end
      end
      S_DIVX, S_DIVY: begin
        if (rdph_q == 2'd0) begin
          dv_start = 1'b1;
          dv_num = NW'(prod);
          dv_den = TW'(len_q);
          rdph_d = 2'd1;
        end else if (dv_done) begin
          rdph_d = 2'd0;
          if (state_q == S_DIVX) begin
            rsp_d.pos_x = CW'(qs + (CW+2)'(x0_q));
            state_d = S_DIVY;
          end else begin
            rsp_d.pos_y = CW'(qs + (CW+2)'(y0_q));
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  property p_one_rsp;
    @(posedge clk_i) disable iff (!rst_ni) (req.valid && req.ready) |=> !req.ready;
  endproperty
  assert property (p_one_rsp) else $error("request accepted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxPoints)) else $error("point count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> rsp.valid) else $error("result lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> state_q == S_IDLE) else $error("busy while result pending");
endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench of polyline_point_at_time
// Drives clear, append, query and unused ops with random idling on both sides,
// predicts each result from a local copy of the path and checks it field by
// field. The duration register is rewritten between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int NPts = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [plpat_pkg::TimeW-1:0] cfg_wdata_i = '0;

  plpat_req_if req ();
  plpat_rsp_if rsp ();

  polyline_point_at_time uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [15:0] path_x [NPts];
  logic [15:0] path_y [NPts];
  logic [16:0] seg_len [NPts];
  int unsigned n_points;
  logic [20:0] path_total;
  logic [15:0] duration;

  plpat_pkg::rsp_t pending_pos [$];
  int errors;
  bit quiet;
  bit req_stall_on, rsp_stall_on;
  int rsp_idle = 0;

  typedef struct {
    plpat_pkg::req_t r;
    bit              known;
    plpat_pkg::rsp_t res;
  } vec_t;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd4294967296;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic plpat_pkg::rsp_t locate_point(plpat_pkg::req_t r);
    plpat_pkg::rsp_t o;
    longint signed dx, dy, x0, y0, m, ln;
    longint unsigned travel, run, tot;
    int unsigned lastp;
    o = '0;
    case (plpat_pkg::op_e'(r.operation))
      plpat_pkg::OP_CLEAR: begin
        n_points = 0;
        path_total = '0;
      end
      plpat_pkg::OP_APPEND: begin
        if (n_points >= NPts) begin
          o.status = plpat_pkg::ST_FULL;
        end else begin
          path_x[n_points] = r.point_x;
          path_y[n_points] = r.point_y;
          if (n_points >= 1) begin
            dx = longint'($signed(r.point_x)) - longint'($signed(path_x[n_points-1]));
            dy = longint'($signed(r.point_y)) - longint'($signed(path_y[n_points-1]));
            ln = longint'(root_floor(longint'(dx * dx + dy * dy)));
            seg_len[n_points-1] = ln[16:0];
            tot = path_total + ln;
            path_total = (tot > 64'h1FFFFF) ? 21'h1FFFFF : tot[20:0];
          end
          n_points++;
        end
      end
      plpat_pkg::OP_QUERY: begin
        if (n_points == 0) begin
          o.status = plpat_pkg::ST_EMPTY;
        end else begin
          lastp = n_points - 1;
          o.pos_x = path_x[lastp];
          o.pos_y = path_y[lastp];
          o.segment_index = (n_points >= 2) ? 4'(n_points - 2) : 4'd0;
          if (n_points >= 2 && r.query_time < duration) begin
            if (r.query_time == 0) begin
              o.pos_x = path_x[0];
              o.pos_y = path_y[0];
              o.segment_index = '0;
            end else begin
              travel = (longint'(path_total) * r.query_time) / duration;
              run = 0;
              for (int i = 0; i + 1 < n_points; i++) begin
                ln = longint'(seg_len[i]);
                run += ln;
                if (run >= travel) begin
                  x0 = longint'($signed(path_x[i]));
                  y0 = longint'($signed(path_y[i]));
                  o.segment_index = 4'(i);
                  if (ln == 0) begin
                    o.pos_x = 16'(x0);
                    o.pos_y = 16'(y0);
                  end else begin
                    m = travel - (run - ln);
                    dx = longint'($signed(path_x[i+1])) - x0;
                    dy = longint'($signed(path_y[i+1])) - y0;
                    o.pos_x = 16'(x0 + (dx * m) / ln);
                    o.pos_y = 16'(y0 + (dy * m) / ln);
                  end
                  break;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_item(plpat_pkg::req_t r, bit known, plpat_pkg::rsp_t res);
    plpat_pkg::rsp_t p;
    if (!quiet && req_stall_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    p = locate_point(r);
    if (known && p != res) begin
      $error("table row disagrees with predictor for op %0d", r.operation);
      errors++;
    end
    pending_pos.push_back(p);
    req.valid <= 1'b1;
    req.data <= r;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_pos.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic set_duration(logic [15:0] d);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= d;
    duration = d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic plpat_pkg::req_t mk(plpat_pkg::op_e op, int x, int y, int t);
    plpat_pkg::req_t r;
    r.operation = op;
    r.point_x = 16'(x);
    r.point_y = 16'(y);
    r.query_time = 16'(t);
    return r;
  endfunction

  function automatic plpat_pkg::rsp_t rs(int x, int y, int s, plpat_pkg::status_e st);
    plpat_pkg::rsp_t o;
    o.pos_x = 16'(x);
    o.pos_y = 16'(y);
    o.segment_index = 4'(s);
    o.status = st;
    return o;
  endfunction

  // response side: random stall bursts, compare against the queue
  always @(negedge clk_i) begin
    if (!rst_ni || quiet || !rsp_stall_on) begin
      rsp_idle = 0;
      rsp.ready <= 1'b1;
    end else if (rsp_idle > 0) begin
      rsp_idle--;
      rsp.ready <= (rsp_idle == 0);
    end else if ($urandom_range(0, 4) == 0) begin
      rsp_idle = $urandom_range(1, 6);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    plpat_pkg::rsp_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_pos.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = pending_pos.pop_front();
        if (rsp.data.pos_x !== e.pos_x) begin
          $error("pos_x exp %0d got %0d", $signed(e.pos_x), $signed(rsp.data.pos_x));
          errors++;
        end
        if (rsp.data.pos_y !== e.pos_y) begin
          $error("pos_y exp %0d got %0d", $signed(e.pos_y), $signed(rsp.data.pos_y));
          errors++;
        end
        if (rsp.data.segment_index !== e.segment_index) begin
          $error("segment_index exp %0d got %0d", e.segment_index, rsp.data.segment_index);
          errors++;
        end
        if (rsp.data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.data.status);
          errors++;
        end
      end
    end
  end

  task automatic random_phase(int count);
    plpat_pkg::req_t r;
    int k;
    for (k = 0; k < count; k++) begin
      req_stall_on = ($urandom_range(0, 9) != 0);
      rsp_stall_on = req_stall_on;
      case ($urandom_range(0, 19))
        0: r = mk(plpat_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
        1: r = mk(plpat_pkg::OP_NONE, $urandom, $urandom, $urandom);
        2, 3, 4, 5, 6: begin
          // mostly short steps, sometimes full range
          if ($urandom_range(0, 3) == 0)
            r = mk(plpat_pkg::OP_APPEND, $urandom, $urandom, $urandom);
          else
            r = mk(plpat_pkg::OP_APPEND, $urandom_range(0, 4000) - 2000,
                   $urandom_range(0, 4000) - 2000, $urandom);
        end
        default: begin
          if ($urandom_range(0, 4) == 0)
            r = mk(plpat_pkg::OP_QUERY, $urandom, $urandom, $urandom);
          else
            r = mk(plpat_pkg::OP_QUERY, $urandom, $urandom, $urandom_range(0, duration));
        end
      endcase
      if (n_points >= NPts && $urandom_range(0, 2) != 0)
        r = mk(plpat_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
      send_item(r, 1'b0, '0);
    end
  endtask

  initial begin
    vec_t dir [$];
    errors = 0;
    quiet = 0;
    req_stall_on = 1;
    rsp_stall_on = 1;
    n_points = 0;
    path_total = '0;
    duration = plpat_pkg::DurationReset;
    req.valid = 1'b0;
    req.data = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    dir.push_back('{mk(plpat_pkg::OP_QUERY, 0, 0, 5), 1,
                   rs(0, 0, 0, plpat_pkg::ST_EMPTY)});
    dir.push_back('{mk(plpat_pkg::OP_NONE, -1, -1, 65535), 1,
                   rs(0, 0, 0, plpat_pkg::ST_DONE)});
    dir.push_back('{mk(plpat_pkg::OP_APPEND, -32768, 32767, 0), 1,
                   rs(0, 0, 0, plpat_pkg::ST_DONE)});
    dir.push_back('{mk(plpat_pkg::OP_QUERY, 0, 0, 500), 1,
                   rs(-32768, 32767, 0, plpat_pkg::ST_DONE)});
    dir.push_back('{mk(plpat_pkg::OP_APPEND, 32767, -32768, 0), 1,
                   rs(0, 0, 0, plpat_pkg::ST_DONE)});
    dir.push_back('{mk(plpat_pkg::OP_QUERY, 0, 0, 0), 1,
                   rs(-32768, 32767, 0, plpat_pkg::ST_DONE)});
    dir.push_back('{mk(plpat_pkg::OP_QUERY, 0, 0, 1000), 1,
                   rs(32767, -32768, 0, plpat_pkg::ST_DONE)});
    dir.push_back('{mk(plpat_pkg::OP_QUERY, 0, 0, 65535), 1,
                   rs(32767, -32768, 0, plpat_pkg::ST_DONE)});
    dir.push_back('{mk(plpat_pkg::OP_QUERY, 0, 0, 500), 0, '0});
    dir.push_back('{mk(plpat_pkg::OP_APPEND, 32767, -32768, 0), 0, '0});
    dir.push_back('{mk(plpat_pkg::OP_APPEND, -32768, 32767, 0), 0, '0});
    dir.push_back('{mk(plpat_pkg::OP_QUERY, 0, 0, 999), 0, '0});
    dir.push_back('{mk(plpat_pkg::OP_QUERY, 0, 0, 1), 0, '0});
    for (int i = 0; i < 13; i++)
      dir.push_back('{mk(plpat_pkg::OP_APPEND, (i % 2) ? 32767 : -32768,
                         (i % 2) ? -32768 : 32767, 0), 0, '0});
    dir.push_back('{mk(plpat_pkg::OP_APPEND, 5, 5, 0), 1,
                   rs(0, 0, 0, plpat_pkg::ST_FULL)});
    dir.push_back('{mk(plpat_pkg::OP_QUERY, 0, 0, 700), 0, '0});
    dir.push_back('{mk(plpat_pkg::OP_QUERY, 0, 0, 999), 0, '0});
    dir.push_back('{mk(plpat_pkg::OP_CLEAR, 0, 0, 0), 1,
                   rs(0, 0, 0, plpat_pkg::ST_DONE)});
    foreach (dir[i]) send_item(dir[i].r, dir[i].known, dir[i].res);
    drain();

    set_duration(16'd1);
    random_phase(200);
    drain();
    set_duration(16'd65535);
    random_phase(250);
    drain();
    set_duration(16'd37);
    random_phase(300);
    drain();
    set_duration(16'd1000);
    quiet = 1;
    random_phase(250);
    drain();

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
rtl/plpat_pkg.sv
rtl/plpat_if.sv
rtl/plpat_ram.sv
rtl/plpat_divu.sv
rtl/polyline_point_at_time.sv
test/tb.sv
